@@ src/jjk_pkg.sv @@
// Shared types, constants and the quarter-wave sine table for the joystick jog block.
// No dependencies; the top level refers to it by scoped names and the testbench imports it.
`timescale 1ns / 1ps
`default_nettype none

package jjk_pkg;

    // position format
    localparam int POS_W = 21;
    localparam logic [POS_W-1:0] POS_MAX = 21'h0FFFFF;
    localparam logic [POS_W-1:0] POS_MIN = 21'h100000;

    // default fixed-point settings
    localparam int POS_FRAC_BITS_DEF = 10;
    localparam int TRIG_FRAC_BITS_DEF = 15;

    // item field widths
    localparam int HEAD_W = 9;
    localparam int DEFL_W = 8;
    localparam int GAIN_W = 16;
    localparam int SINE_W = 16;
    localparam int SINE_IDX_W = 7;

    // angle constants, whole degrees
    localparam int ANGLE_W = 10;
    localparam logic [ANGLE_W-1:0] DEG_90 = 10'd90;
    localparam logic [ANGLE_W-1:0] DEG_180 = 10'd180;
    localparam logic [ANGLE_W-1:0] DEG_270 = 10'd270;
    localparam logic [ANGLE_W-1:0] ANGLE_STEPS = 10'd360;

    // register map
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam logic [2:0] REG_STEP_GAIN = 3'd0;
    localparam logic [2:0] REG_BOX_LEFT = 3'd1;
    localparam logic [2:0] REG_BOX_TOP = 3'd2;
    localparam logic [2:0] REG_BOX_RIGHT = 3'd3;
    localparam logic [2:0] REG_BOX_BOTTOM = 3'd4;
    localparam logic [GAIN_W-1:0] STEP_GAIN_RST = 16'd655;

    // action codes
    localparam logic ACT_JOG = 1'b0;
    localparam logic ACT_LOAD = 1'b1;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_GAIN,
        ST_TGO,
        ST_TRIG,
        ST_SUM,
        ST_FIN
    } state_t;

    // sine table selection for one angle
    typedef struct packed {
        logic                  neg;
        logic [SINE_IDX_W-1:0] idx;
    } sine_sel_t;

    // round(32768 * sin(k degrees)), k = 0..90
    function automatic logic [SINE_W-1:0] sine_q15(input logic [SINE_IDX_W-1:0] k);
        logic [SINE_W-1:0] v;
        unique case (k)
            7'd0: v = 16'd0;      7'd1: v = 16'd572;    7'd2: v = 16'd1144;
            7'd3: v = 16'd1715;   7'd4: v = 16'd2286;   7'd5: v = 16'd2856;
            7'd6: v = 16'd3425;   7'd7: v = 16'd3993;   7'd8: v = 16'd4560;
            7'd9: v = 16'd5126;   7'd10: v = 16'd5690;  7'd11: v = 16'd6252;
            7'd12: v = 16'd6813;  7'd13: v = 16'd7371;  7'd14: v = 16'd7927;
            7'd15: v = 16'd8481;  7'd16: v = 16'd9032;  7'd17: v = 16'd9580;
            7'd18: v = 16'd10126; 7'd19: v = 16'd10668; 7'd20: v = 16'd11207;
            7'd21: v = 16'd11743; 7'd22: v = 16'd12275; 7'd23: v = 16'd12803;
            7'd24: v = 16'd13328; 7'd25: v = 16'd13848; 7'd26: v = 16'd14365;
            7'd27: v = 16'd14876; 7'd28: v = 16'd15384; 7'd29: v = 16'd15886;
            7'd30: v = 16'd16384; 7'd31: v = 16'd16877; 7'd32: v = 16'd17364;
            7'd33: v = 16'd17847; 7'd34: v = 16'd18324; 7'd35: v = 16'd18795;
            7'd36: v = 16'd19261; 7'd37: v = 16'd19720; 7'd38: v = 16'd20174;
            7'd39: v = 16'd20622; 7'd40: v = 16'd21063; 7'd41: v = 16'd21498;
            7'd42: v = 16'd21926; 7'd43: v = 16'd22348; 7'd44: v = 16'd22763;
            7'd45: v = 16'd23170; 7'd46: v = 16'd23571; 7'd47: v = 16'd23965;
            7'd48: v = 16'd24351; 7'd49: v = 16'd24730; 7'd50: v = 16'd25102;
            7'd51: v = 16'd25466; 7'd52: v = 16'd25822; 7'd53: v = 16'd26170;
            7'd54: v = 16'd26510; 7'd55: v = 16'd26842; 7'd56: v = 16'd27166;
            7'd57: v = 16'd27482; 7'd58: v = 16'd27789; 7'd59: v = 16'd28088;
            7'd60: v = 16'd28378; 7'd61: v = 16'd28660; 7'd62: v = 16'd28932;
            7'd63: v = 16'd29197; 7'd64: v = 16'd29452; 7'd65: v = 16'd29698;
            7'd66: v = 16'd29935; 7'd67: v = 16'd30163; 7'd68: v = 16'd30382;
            7'd69: v = 16'd30592; 7'd70: v = 16'd30792; 7'd71: v = 16'd30983;
            7'd72: v = 16'd31164; 7'd73: v = 16'd31336; 7'd74: v = 16'd31499;
            7'd75: v = 16'd31651; 7'd76: v = 16'd31795; 7'd77: v = 16'd31928;
            7'd78: v = 16'd32052; 7'd79: v = 16'd32166; 7'd80: v = 16'd32270;
            7'd81: v = 16'd32365; 7'd82: v = 16'd32449; 7'd83: v = 16'd32524;
            7'd84: v = 16'd32588; 7'd85: v = 16'd32643; 7'd86: v = 16'd32688;
            7'd87: v = 16'd32723; 7'd88: v = 16'd32748; 7'd89: v = 16'd32763;
            7'd90: v = 16'd32768;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ src/jjk_serial_mul.sv @@
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
// Uses no package items; instantiated by the joystick jog top level.
`timescale 1ns / 1ps
`default_nettype none

module jjk_serial_mul #(
    parameter int A_W = 16,
    parameter int B_W = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [A_W-1:0]     a,
    input  logic [B_W-1:0]     b,
    output logic               done,
    output logic [A_W+B_W-1:0] product
);

    localparam int CNT_W = $clog2(B_W + 1);

    logic               busy_reg, busy_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [A_W-1:0]     a_reg;
    logic [B_W-1:0]     b_reg;
    logic [A_W+B_W-1:0] acc_reg;
    logic [A_W:0]       part_sum;

    // control: count down multiplier bits
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next = cnt_reg;
        done = busy_reg && (cnt_reg == CNT_W'(1));
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next = CNT_W'(B_W);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
            if (done)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    // add the multiplicand on the high half when the low multiplier bit is set
    assign part_sum = {1'b0, acc_reg[A_W+B_W-1:B_W]} + (b_reg[0] ? {1'b0, a_reg} : '0);

    // datapath: shift right one bit per step
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            b_reg <= b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            b_reg <= b_reg >> 1;
            acc_reg <= {part_sum, acc_reg[B_W-1:1]};
        end
    end

    assign product = acc_reg;

endmodule

`default_nettype wire

@@ src/joystick_jog_with_keepout_box.sv @@
// Joystick jog of a target point with a keep-out box: register port, sequencer and datapath.
// Depends on jjk_pkg and jjk_serial_mul.
`timescale 1ns / 1ps
`default_nettype none

// The block holds a target point in signed Q10.10 and returns it once for every
// transaction. A jog transaction steps the point by deflection * step_gain times
// the cosine (x) and sine (y) of the heading, saturates it, and pushes it to a
// keep-out box edge if it lands strictly inside the box; a load transaction sets
// the point directly. Work is done by bit-serial multipliers: the deflection
// times gain pass comes first and the two trig passes then run side by side; a
// load skips them. The block accepts no new transaction until the current result
// is loaded into the output register. A finished result waits in the output
// register; the next transaction is accepted while it waits, and the block holds
// only when a second result is ready before the first is taken. Registers are
// written through the APB-style port at byte address 4 * index; the user must
// write them only while the block is idle, which the block does not enforce.

module joystick_jog_with_keepout_box #(
    parameter int POS_FRAC_BITS = jjk_pkg::POS_FRAC_BITS_DEF,
    parameter int TRIG_FRAC_BITS = jjk_pkg::TRIG_FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [jjk_pkg::ADDR_W-1:0]        paddr,
    input  logic [jjk_pkg::DATA_W-1:0]        pwdata,
    output logic [jjk_pkg::DATA_W-1:0]        prdata,
    output logic                              pready,
    // input channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              action,
    input  logic [jjk_pkg::HEAD_W-1:0]        heading_deg,
    input  logic [jjk_pkg::DEFL_W-1:0]        deflection,
    input  logic signed [jjk_pkg::POS_W-1:0]  load_x,
    input  logic signed [jjk_pkg::POS_W-1:0]  load_y,
    // output channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [jjk_pkg::POS_W-1:0]  point_x,
    output logic signed [jjk_pkg::POS_W-1:0]  point_y,
    output logic                              pushed_out
);

    localparam int TRIG_W = TRIG_FRAC_BITS + 1;
    localparam int TFULL_W = TRIG_FRAC_BITS + 17;
    localparam int P1_W = jjk_pkg::GAIN_W + jjk_pkg::DEFL_W;
    localparam int PROD_W = P1_W + TRIG_W;
    localparam int SHIFT = jjk_pkg::GAIN_W + TRIG_FRAC_BITS - POS_FRAC_BITS;
    localparam int MOVE_W = PROD_W - SHIFT + 1;
    localparam int SUM_W = ((MOVE_W > jjk_pkg::POS_W) ? MOVE_W : jjk_pkg::POS_W) + 2;

    // register file
    logic [jjk_pkg::GAIN_W-1:0]       step_gain_reg;
    logic signed [jjk_pkg::POS_W-1:0] box_left_reg, box_top_reg;
    logic signed [jjk_pkg::POS_W-1:0] box_right_reg, box_bottom_reg;
    logic                             cfg_wr;

    // sequencer
    jjk_pkg::state_t state_reg, state_next;
    logic            accept, look_en, gain_start, trig_start, sum_en, load_out;

    // datapath
    logic [jjk_pkg::ANGLE_W-1:0]      head_ext, ang_full, ac_sum, ac_full;
    logic [jjk_pkg::HEAD_W-1:0]       ang_reg, ac_reg;
    logic [jjk_pkg::DEFL_W-1:0]       defl_reg;
    jjk_pkg::sine_sel_t               sel_x, sel_y;
    logic [TFULL_W-1:0]               tfull_x, tfull_y;
    logic [TRIG_W-1:0]                trig_x_reg, trig_y_reg;
    logic                             neg_x_reg, neg_y_reg;
    logic                             gain_done, trig_done, trig_done_y;
    logic [P1_W-1:0]                  p1;
    logic [PROD_W-1:0]                prod_x, prod_y;
    logic signed [jjk_pkg::POS_W-1:0] nx_reg, ny_reg;
    logic                             jog_reg;
    logic signed [jjk_pkg::POS_W-1:0] pos_x_reg, pos_y_reg;
    logic signed [jjk_pkg::POS_W:0]   dx, dy;
    logic [jjk_pkg::POS_W:0]          adx, ady;
    logic                             in_box;
    logic signed [jjk_pkg::POS_W-1:0] fx, fy;
    logic                             fpush;

    // output register
    logic                             out_valid_reg, out_valid_next;
    logic signed [jjk_pkg::POS_W-1:0] point_x_reg, point_y_reg;
    logic                             pushed_reg;

    // table index and sign for a reduced angle
    function automatic jjk_pkg::sine_sel_t sine_sel(input logic [jjk_pkg::HEAD_W-1:0] ang);
        logic [jjk_pkg::ANGLE_W-1:0] a;
        logic [jjk_pkg::ANGLE_W-1:0] t;
        jjk_pkg::sine_sel_t          s;
        a = {1'b0, ang};
        priority if (a <= jjk_pkg::DEG_90)
        begin
            t = a;
            s.neg = 1'b0;
        end
        else if (a <= jjk_pkg::DEG_180)
        begin
            t = jjk_pkg::DEG_180 - a;
            s.neg = 1'b0;
        end
        else if (a <= jjk_pkg::DEG_270)
        begin
            t = a - jjk_pkg::DEG_180;
            s.neg = 1'b1;
        end
        else
        begin
            t = jjk_pkg::ANGLE_STEPS - a;
            s.neg = 1'b1;
        end
        s.idx = t[jjk_pkg::SINE_IDX_W-1:0];
        return s;
    endfunction

    // rounded move added to or taken from one axis, saturated
    function automatic logic signed [jjk_pkg::POS_W-1:0] jog_axis(
        input logic signed [jjk_pkg::POS_W-1:0] pos,
        input logic [PROD_W-1:0]                prod,
        input logic                             neg
    );
        logic [MOVE_W-1:0]        move;
        logic signed [SUM_W-1:0]  pos_e, move_e, s, hi, lo;
        move = {1'b0, prod[PROD_W-1:SHIFT]} + MOVE_W'(prod[SHIFT-1]);
        pos_e = {{(SUM_W - jjk_pkg::POS_W){pos[jjk_pkg::POS_W-1]}}, pos};
        move_e = {{(SUM_W - MOVE_W){1'b0}}, move};
        hi = {{(SUM_W - jjk_pkg::POS_W){1'b0}}, jjk_pkg::POS_MAX};
        lo = {{(SUM_W - jjk_pkg::POS_W){1'b1}}, jjk_pkg::POS_MIN};
        s = neg ? (pos_e - move_e) : (pos_e + move_e);
        if (s > hi)
        begin
            s = hi;
        end
        else if (s < lo)
        begin
            s = lo;
        end
        return s[jjk_pkg::POS_W-1:0];
    endfunction

    // configuration writes
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_gain_reg <= jjk_pkg::STEP_GAIN_RST;
            box_left_reg <= '0;
            box_top_reg <= '0;
            box_right_reg <= '0;
            box_bottom_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:2])
                jjk_pkg::REG_STEP_GAIN: step_gain_reg <= pwdata[jjk_pkg::GAIN_W-1:0];
                jjk_pkg::REG_BOX_LEFT: box_left_reg <= pwdata[jjk_pkg::POS_W-1:0];
                jjk_pkg::REG_BOX_TOP: box_top_reg <= pwdata[jjk_pkg::POS_W-1:0];
                jjk_pkg::REG_BOX_RIGHT: box_right_reg <= pwdata[jjk_pkg::POS_W-1:0];
                jjk_pkg::REG_BOX_BOTTOM: box_bottom_reg <= pwdata[jjk_pkg::POS_W-1:0];
                default: ;
            endcase
        end
    end

    // configuration reads
    always_comb
    begin
        unique case (paddr[4:2])
            jjk_pkg::REG_STEP_GAIN:
                prdata = {{(jjk_pkg::DATA_W - jjk_pkg::GAIN_W){1'b0}}, step_gain_reg};
            jjk_pkg::REG_BOX_LEFT:
                prdata = {{(jjk_pkg::DATA_W - jjk_pkg::POS_W){box_left_reg[20]}}, box_left_reg};
            jjk_pkg::REG_BOX_TOP:
                prdata = {{(jjk_pkg::DATA_W - jjk_pkg::POS_W){box_top_reg[20]}}, box_top_reg};
            jjk_pkg::REG_BOX_RIGHT:
                prdata = {{(jjk_pkg::DATA_W - jjk_pkg::POS_W){box_right_reg[20]}},
                          box_right_reg};
            jjk_pkg::REG_BOX_BOTTOM:
                prdata = {{(jjk_pkg::DATA_W - jjk_pkg::POS_W){box_bottom_reg[20]}},
                          box_bottom_reg};
            default: prdata = '0;
        endcase
    end

    // sequencer state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= jjk_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // sequencer next state and strobes
    always_comb
    begin
        state_next = state_reg;
        in_stall = 1'b1;
        accept = 1'b0;
        look_en = 1'b0;
        gain_start = 1'b0;
        trig_start = 1'b0;
        sum_en = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            jjk_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                accept = in_valid;
                if (in_valid)
                begin
                    state_next = (action == jjk_pkg::ACT_LOAD) ? jjk_pkg::ST_FIN
                                                               : jjk_pkg::ST_LOOK;
                end
            end
            jjk_pkg::ST_LOOK:
            begin
                look_en = 1'b1;
                gain_start = 1'b1;
                state_next = jjk_pkg::ST_GAIN;
            end
            jjk_pkg::ST_GAIN:
            begin
                if (gain_done)
                begin
                    state_next = jjk_pkg::ST_TGO;
                end
            end
            jjk_pkg::ST_TGO:
            begin
                trig_start = 1'b1;
                state_next = jjk_pkg::ST_TRIG;
            end
            jjk_pkg::ST_TRIG:
            begin
                if (trig_done && trig_done_y)
                begin
                    state_next = jjk_pkg::ST_SUM;
                end
            end
            jjk_pkg::ST_SUM:
            begin
                sum_en = 1'b1;
                state_next = jjk_pkg::ST_FIN;
            end
            jjk_pkg::ST_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out = 1'b1;
                    state_next = jjk_pkg::ST_IDLE;
                end
            end
            default: state_next = jjk_pkg::ST_IDLE;
        endcase
    end

    // heading reduced to 0..359, cosine taken as sine of heading + 90
    always_comb
    begin
        head_ext = {1'b0, heading_deg};
        ang_full = (head_ext >= jjk_pkg::ANGLE_STEPS) ? (head_ext - jjk_pkg::ANGLE_STEPS)
                                                      : head_ext;
        ac_sum = ang_full + jjk_pkg::DEG_90;
        ac_full = (ac_sum >= jjk_pkg::ANGLE_STEPS) ? (ac_sum - jjk_pkg::ANGLE_STEPS) : ac_sum;
    end

    // table lookup and rescale to the trig format
    always_comb
    begin
        sel_x = sine_sel(ac_reg);
        sel_y = sine_sel(ang_reg);
        tfull_x = ({{(TRIG_FRAC_BITS + 1){1'b0}}, jjk_pkg::sine_q15(sel_x.idx)}
                   << TRIG_FRAC_BITS) + TFULL_W'(16384);
        tfull_y = ({{(TRIG_FRAC_BITS + 1){1'b0}}, jjk_pkg::sine_q15(sel_y.idx)}
                   << TRIG_FRAC_BITS) + TFULL_W'(16384);
    end

    // transaction capture, lookup and sum registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ang_reg <= ang_full[jjk_pkg::HEAD_W-1:0];
            ac_reg <= ac_full[jjk_pkg::HEAD_W-1:0];
            defl_reg <= deflection;
            jog_reg <= (action == jjk_pkg::ACT_JOG);
            nx_reg <= load_x;
            ny_reg <= load_y;
        end
        else if (sum_en)
        begin
            nx_reg <= jog_axis(pos_x_reg, prod_x, neg_x_reg);
            ny_reg <= jog_axis(pos_y_reg, prod_y, neg_y_reg);
        end
        if (look_en)
        begin
            trig_x_reg <= tfull_x[15 +: TRIG_W];
            trig_y_reg <= tfull_y[15 +: TRIG_W];
            neg_x_reg <= sel_x.neg;
            neg_y_reg <= sel_y.neg;
        end
    end

    // deflection times gain
    jjk_serial_mul #(
        .A_W(jjk_pkg::GAIN_W),
        .B_W(jjk_pkg::DEFL_W)
    ) u_gain_mul (
        .clk(clk),
        .rst_n(rst_n),
        .start(gain_start),
        .a(step_gain_reg),
        .b(defl_reg),
        .done(gain_done),
        .product(p1)
    );

    // scaled deflection times cosine and sine, side by side
    jjk_serial_mul #(
        .A_W(P1_W),
        .B_W(TRIG_W)
    ) u_trig_mul_x (
        .clk(clk),
        .rst_n(rst_n),
        .start(trig_start),
        .a(p1),
        .b(trig_x_reg),
        .done(trig_done),
        .product(prod_x)
    );

    jjk_serial_mul #(
        .A_W(P1_W),
        .B_W(TRIG_W)
    ) u_trig_mul_y (
        .clk(clk),
        .rst_n(rst_n),
        .start(trig_start),
        .a(p1),
        .b(trig_y_reg),
        .done(trig_done_y),
        .product(prod_y)
    );

    // keep-out test and push on the axis with the larger move
    always_comb
    begin
        dx = {nx_reg[jjk_pkg::POS_W-1], nx_reg} - {pos_x_reg[jjk_pkg::POS_W-1], pos_x_reg};
        dy = {ny_reg[jjk_pkg::POS_W-1], ny_reg} - {pos_y_reg[jjk_pkg::POS_W-1], pos_y_reg};
        adx = (dx < 0) ? -dx : dx;
        ady = (dy < 0) ? -dy : dy;
        in_box = jog_reg && (nx_reg > box_left_reg) && (nx_reg < box_right_reg) &&
                 (ny_reg > box_top_reg) && (ny_reg < box_bottom_reg);
        fx = nx_reg;
        fy = ny_reg;
        fpush = in_box;
        if (in_box)
        begin
            if (adx > ady)
            begin
                fx = (dx > 0) ? box_left_reg : box_right_reg;
            end
            else
            begin
                fy = (dy > 0) ? box_top_reg : box_bottom_reg;
            end
        end
    end

    // point state and output handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pos_x_reg <= '0;
            pos_y_reg <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (load_out)
            begin
                pos_x_reg <= fx;
                pos_y_reg <= fy;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            point_x_reg <= fx;
            point_y_reg <= fy;
            pushed_reg <= fpush;
        end
    end

    assign out_valid = out_valid_reg;
    assign point_x = point_x_reg;
    assign point_y = point_y_reg;
    assign pushed_out = pushed_reg;

endmodule

`default_nettype wire

@@ src/jjk_checker.sv @@
// Port-level checks for the joystick jog block, attached to the top level by bind.
// Depends on the top level's port names only.
`timescale 1ns / 1ps
`default_nettype none

module jjk_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [20:0] point_x,
    input logic [20:0] point_y,
    input logic        pushed_out
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(point_x) && $stable(point_y) && $stable(pushed_out))
        else $error("result payload changed while stalled");

    // one transaction at a time: busy right after acceptance
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted back to back");

    // a result never appears in the cycle after an acceptance
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !$rose(out_valid))
        else $error("result appeared too early");

    // a new result comes only at the end of a transaction's work
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without work in progress");

endmodule

bind joystick_jog_with_keepout_box jjk_checker u_jjk_checker (.*);

`default_nettype wire

@@ tb/sv/tb_joystick_jog_with_keepout_box.sv @@
// Self-checking testbench for the joystick jog block with keep-out box.
// Holds its own model of the point update in a scoreboard class; needs jjk_pkg and the block.
`timescale 1ns / 1ps

module tb_joystick_jog_with_keepout_box;

    import jjk_pkg::*;

    localparam int POS_FRAC = POS_FRAC_BITS_DEF;
    localparam int TRIG_FRAC = TRIG_FRAC_BITS_DEF;
    localparam int MOVE_SHIFT = 16 + TRIG_FRAC - POS_FRAC;
    localparam longint POS_HI = 1048575;
    localparam longint POS_LO = -1048576;
    localparam int RESET_CYCLES = 8;
    localparam int DRAIN_CYCLES = 64;
    localparam int LONG_HOLD = 400;
    localparam int NEAR_MARGIN = 4096;
    localparam int MAX_PRINTS = 100;
    localparam longint TIMEOUT_NS = 1000000;
    localparam logic [2:0] REG_UNUSED = 3'd5;

    // round(32768 * sin(k degrees)), k = 0..90
    localparam int SINE_TAB [0:90] = '{
            0,   572,  1144,  1715,  2286,  2856,  3425,  3993,  4560,  5126,
         5690,  6252,  6813,  7371,  7927,  8481,  9032,  9580, 10126, 10668,
        11207, 11743, 12275, 12803, 13328, 13848, 14365, 14876, 15384, 15886,
        16384, 16877, 17364, 17847, 18324, 18795, 19261, 19720, 20174, 20622,
        21063, 21498, 21926, 22348, 22763, 23170, 23571, 23965, 24351, 24730,
        25102, 25466, 25822, 26170, 26510, 26842, 27166, 27482, 27789, 28088,
        28378, 28660, 28932, 29197, 29452, 29698, 29935, 30163, 30382, 30592,
        30792, 30983, 31164, 31336, 31499, 31651, 31795, 31928, 32052, 32166,
        32270, 32365, 32449, 32524, 32588, 32643, 32688, 32723, 32748, 32763,
        32768
    };

    typedef struct {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic                    pushed;
    } point_result_t;

    typedef enum int {
        SINK_FREE,
        SINK_LIGHT,
        SINK_HEAVY,
        SINK_TOGGLE
    } sink_mode_t;

    // point tracker: shadow registers, shadow point and the queue of expected points
    class jog_scoreboard;
        int unsigned   step_gain_r;
        longint        box_l, box_t, box_r, box_b;
        longint        cur_x, cur_y;
        point_result_t expected_points[$];
        int            errors, n_checked, n_jogs, n_loads, n_pushed;

        function new();
            step_gain_r = STEP_GAIN_RST;
            box_l = 0;
            box_t = 0;
            box_r = 0;
            box_b = 0;
            cur_x = 0;
            cur_y = 0;
            errors = 0;
            n_checked = 0;
            n_jogs = 0;
            n_loads = 0;
            n_pushed = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] value);
            logic signed [POS_W-1:0] edge_pos;
            edge_pos = value[POS_W-1:0];
            case (idx)
                REG_STEP_GAIN:  step_gain_r = value[GAIN_W-1:0];
                REG_BOX_LEFT:   box_l = edge_pos;
                REG_BOX_TOP:    box_t = edge_pos;
                REG_BOX_RIGHT:  box_r = edge_pos;
                REG_BOX_BOTTOM: box_b = edge_pos;
                default: ;
            endcase
        endfunction

        // sine magnitude and sign for a whole degree 0..359
        function longint unsigned sine_mag(int unsigned deg, output bit neg);
            neg = 1'b0;
            if (deg <= 90)
                return SINE_TAB[deg];
            if (deg <= 180)
                return SINE_TAB[180 - deg];
            neg = 1'b1;
            if (deg <= 270)
                return SINE_TAB[deg - 180];
            return SINE_TAB[(360 - deg) % 91];
        endfunction

        // one axis: scaled trig step, rounded half away from zero, then saturated
        function longint step_axis(longint pos, int unsigned defl, int unsigned deg);
            bit neg;
            longint unsigned mag, trig, prod, move;
            longint sum;
            mag = sine_mag(deg, neg);
            trig = ((mag << TRIG_FRAC) + (64'd1 << 14)) >> 15;
            prod = longint'(defl) * longint'(step_gain_r) * trig;
            move = (prod + (64'd1 << (MOVE_SHIFT - 1))) >> MOVE_SHIFT;
            if (move > (64'd1 << 40))
                move = 64'd1 << 40;
            sum = neg ? pos - longint'(move) : pos + longint'(move);
            if (sum > POS_HI)
                sum = POS_HI;
            if (sum < POS_LO)
                sum = POS_LO;
            return sum;
        endfunction

        function void note_item(logic act, logic [HEAD_W-1:0] hd, logic [DEFL_W-1:0] dfl,
                                logic signed [POS_W-1:0] lx, logic signed [POS_W-1:0] ly);
            int unsigned deg, deg_x;
            longint nx, ny, dx, dy, adx, ady;
            point_result_t res;
            res.pushed = 1'b0;
            if (act == ACT_LOAD)
            begin
                cur_x = lx;
                cur_y = ly;
                n_loads++;
            end
            else
            begin
                deg = hd % int'(ANGLE_STEPS);
                deg_x = (deg + 90) % int'(ANGLE_STEPS);
                nx = step_axis(cur_x, dfl, deg_x);
                ny = step_axis(cur_y, dfl, deg);
                // strictly inside the box: push out along the axis of larger move
                if (nx > box_l && nx < box_r && ny > box_t && ny < box_b)
                begin
                    dx = nx - cur_x;
                    dy = ny - cur_y;
                    adx = dx < 0 ? -dx : dx;
                    ady = dy < 0 ? -dy : dy;
                    if (adx > ady)
                        nx = dx > 0 ? box_l : box_r;
                    else
                        ny = dy > 0 ? box_t : box_b;
                    res.pushed = 1'b1;
                    n_pushed++;
                end
                cur_x = nx;
                cur_y = ny;
                n_jogs++;
            end
            res.x = cur_x[POS_W-1:0];
            res.y = cur_y[POS_W-1:0];
            expected_points.push_back(res);
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= MAX_PRINTS)
                $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        task check_point(logic signed [POS_W-1:0] px, logic signed [POS_W-1:0] py,
                         logic po);
            point_result_t want;
            n_checked++;
            if (expected_points.size() == 0)
            begin
                report_mismatch($sformatf("result %0d arrived with no transaction waiting",
                                          n_checked));
                return;
            end
            want = expected_points.pop_front();
            if (px !== want.x)
                report_mismatch($sformatf("result %0d point_x %0d, expected %0d",
                                          n_checked, px, want.x));
            if (py !== want.y)
                report_mismatch($sformatf("result %0d point_y %0d, expected %0d",
                                          n_checked, py, want.y));
            if (po !== want.pushed)
                report_mismatch($sformatf("result %0d pushed_out %0b, expected %0b",
                                          n_checked, po, want.pushed));
        endtask

        function int pending();
            return expected_points.size();
        endfunction
    endclass

    // block ports
    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [ADDR_W-1:0]       paddr = '0;
    logic [DATA_W-1:0]       pwdata = '0;
    logic [DATA_W-1:0]       prdata;
    logic                    pready;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic                    action = ACT_JOG;
    logic [HEAD_W-1:0]       heading_deg = '0;
    logic [DEFL_W-1:0]       deflection = '0;
    logic signed [POS_W-1:0] load_x = '0;
    logic signed [POS_W-1:0] load_y = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic signed [POS_W-1:0] point_x;
    logic signed [POS_W-1:0] point_y;
    logic                    pushed_out;

    jog_scoreboard sb;
    bit            hold_request = 1'b0;
    int            n_reg_writes = 0;

    joystick_jog_with_keepout_box #(
        .POS_FRAC_BITS  (POS_FRAC),
        .TRIG_FRAC_BITS (TRIG_FRAC)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .heading_deg (heading_deg),
        .deflection  (deflection),
        .load_x      (load_x),
        .load_y      (load_y),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .point_x     (point_x),
        .point_y     (point_y),
        .pushed_out  (pushed_out)
    );

    // 2 ns clock
    always #1 clk = ~clk;

    function automatic logic signed [POS_W-1:0] clamp_pos(longint v);
        if (v > POS_HI)
            v = POS_HI;
        if (v < POS_LO)
            v = POS_LO;
        return v[POS_W-1:0];
    endfunction

    // random coordinate in and around the span between two box edges
    function automatic logic signed [POS_W-1:0] near_coord(longint lo, longint hi);
        longint mid, span;
        mid = (lo + hi) / 2;
        span = ((hi > lo) ? hi - lo : lo - hi) / 2 + NEAR_MARGIN;
        return clamp_pos(mid + longint'($urandom_range(0, int'(2 * span))) - span);
    endfunction

    function automatic logic signed [POS_W-1:0] pick_extreme();
        case ($urandom_range(0, 3))
            0: return clamp_pos(POS_LO);
            1: return clamp_pos(POS_HI);
            2: return clamp_pos(0);
            default: return clamp_pos(-1);
        endcase
    endfunction

    // register write: setup cycle, access cycle, then back to idle
    task automatic cfg_write(logic [2:0] idx, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        sb.write_reg(idx, value);
        n_reg_writes++;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_box(longint l, longint t, longint r, longint b);
        cfg_write(REG_BOX_LEFT, 32'(l));
        cfg_write(REG_BOX_TOP, 32'(t));
        cfg_write(REG_BOX_RIGHT, 32'(r));
        cfg_write(REG_BOX_BOTTOM, 32'(b));
    endtask

    // offer one transaction and hold it until the block takes it
    task automatic offer_item(logic act, logic [HEAD_W-1:0] hd, logic [DEFL_W-1:0] dfl,
                              logic signed [POS_W-1:0] lx, logic signed [POS_W-1:0] ly);
        in_valid <= 1'b1;
        action <= act;
        heading_deg <= hd;
        deflection <= dfl;
        load_x <= lx;
        load_y <= ly;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        sb.note_item(act, hd, dfl, lx, ly);
    endtask

    // jog with junk in the load fields
    task automatic do_jog(int unsigned hd, int unsigned dfl);
        logic [31:0] jx, jy;
        jx = $urandom;
        jy = $urandom;
        offer_item(ACT_JOG, hd[HEAD_W-1:0], dfl[DEFL_W-1:0], jx[POS_W-1:0], jy[POS_W-1:0]);
    endtask

    // load with junk heading and deflection
    task automatic do_load(longint x, longint y);
        logic [31:0] junk;
        junk = $urandom;
        offer_item(ACT_LOAD, junk[HEAD_W-1:0], junk[31:24], clamp_pos(x), clamp_pos(y));
    endtask

    // bursts of random transactions with random gaps
    task automatic run_random(int count);
        int left, burst, gap;
        logic [31:0] rx, ry;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(1, 20);
            while (burst > 0 && left > 0)
            begin
                if ($urandom_range(0, 99) < 15)
                begin
                    case ($urandom_range(0, 2))
                        0:
                        begin
                            rx = $urandom;
                            ry = $urandom;
                            do_load(rx[POS_W-1:0] - (rx[POS_W-1] ? 64'sd2097152 : 64'sd0),
                                    ry[POS_W-1:0] - (ry[POS_W-1] ? 64'sd2097152 : 64'sd0));
                        end
                        1: do_load(near_coord(sb.box_l, sb.box_r),
                                   near_coord(sb.box_t, sb.box_b));
                        default: do_load(pick_extreme(), pick_extreme());
                    endcase
                end
                else if ($urandom_range(0, 1) == 0)
                    do_jog($urandom_range(0, 511), $urandom_range(0, 15));
                else
                    do_jog($urandom_range(0, 511), $urandom_range(0, 255));
                burst--;
                left--;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // stop offering until every expected point has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // result side: check accepted points and drive the stall pattern
    initial
    begin : result_sink
        sink_mode_t mode;
        int mode_left, hold_left;
        logic stall_next;
        mode = SINK_FREE;
        mode_left = 0;
        hold_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_stall === 1'b0)
                sb.check_point(point_x, point_y, pushed_out);
            if (hold_request)
            begin
                hold_left = LONG_HOLD;
                hold_request = 1'b0;
            end
            if (mode_left == 0)
            begin
                mode = sink_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(32, 200);
            end
            mode_left--;
            case (mode)
                SINK_FREE:  stall_next = 1'b0;
                SINK_LIGHT: stall_next = ($urandom_range(0, 3) == 0);
                SINK_HEAVY: stall_next = ($urandom_range(0, 3) != 0);
                default:    stall_next = ~out_stall;
            endcase
            if (hold_left > 0)
            begin
                hold_left--;
                stall_next = 1'b1;
            end
            out_stall <= stall_next;
        end
    end

    // stimulus phases
    initial
    begin : stimulus
        longint cx, cy, half;
        sb = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: default gain, empty box; axes, wrap and saturation
        do_jog(0, 0);
        do_jog(0, 255);
        do_jog(90, 255);
        do_jog(180, 255);
        do_jog(270, 255);
        do_jog(359, 255);
        do_jog(360, 200);
        do_jog(511, 200);
        do_load(POS_HI, POS_HI);
        do_jog(45, 255);
        do_load(POS_LO, POS_LO);
        do_jog(225, 255);
        run_random(150);
        drain_results();

        // full gain, box around the origin; each push direction and the edge cases
        cfg_write(REG_STEP_GAIN, 32'd65535);
        set_box(-10000, -10000, 10000, 10000);
        do_load(-12000, 0);
        do_jog(0, 8);
        do_load(12000, 0);
        do_jog(180, 8);
        do_load(0, -12000);
        do_jog(90, 8);
        do_load(0, 12000);
        do_jog(270, 8);
        // zero move inside the box goes to the bottom edge
        do_load(0, 0);
        do_jog(0, 0);
        // landing exactly on the left edge is outside
        do_load(-18192, 0);
        do_jog(0, 8);
        // equal moves on both axes push on y
        do_load(-12000, -12000);
        do_jog(45, 8);
        // long hold-off on the result side while transactions keep coming
        hold_request = 1'b1;
        run_random(200);
        drain_results();

        // zero gain, box over the whole range, plus a write to an unmapped register
        cfg_write(REG_STEP_GAIN, 32'd0);
        set_box(POS_LO, POS_LO, POS_HI, POS_HI);
        cfg_write(REG_UNUSED, $urandom);
        run_random(150);
        drain_results();

        // moderate gain, small box somewhere in the field, with a pause midway
        cfg_write(REG_STEP_GAIN, $urandom_range(100, 4000));
        cx = longint'($urandom_range(0, 1000000)) - 500000;
        cy = longint'($urandom_range(0, 1000000)) - 500000;
        half = $urandom_range(1000, 20000);
        set_box(cx - half, cy - half, cx + half, cy + half);
        run_random(125);
        drain_results();
        run_random(125);
        drain_results();

        // random gain, inverted box: nothing can be inside
        cfg_write(REG_STEP_GAIN, $urandom_range(1, 65535));
        set_box(POS_HI, POS_HI, POS_LO, POS_LO);
        run_random(150);
        drain_results();

        // minimal gain, tiny box around the origin
        cfg_write(REG_STEP_GAIN, 32'd1);
        set_box(-2, -2, 2, 2);
        run_random(200);
        drain_results();

        $display("run covered %0d transactions (%0d jogs, %0d loads, %0d pushed out)",
                 sb.n_jogs + sb.n_loads, sb.n_jogs, sb.n_loads, sb.n_pushed);
        $display("over %0d register writes; %0d results checked, %0d mismatches",
                 n_reg_writes, sb.n_checked, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("** joystick_jog_with_keepout_box: PASSED **");
        else
            $display("** joystick_jog_with_keepout_box: FAILED **");
        $finish;
    end

    // watchdog
    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("timeout with %0d points still expected", sb.pending());
        $display("** joystick_jog_with_keepout_box: FAILED **");
        $finish;
    end

endmodule
